>>> rtl/sdiv_pkg.sv
// ============================================================================
// sdiv_pkg
// Shared constants and types for the saturating signed divider.
// ============================================================================
package sdiv_pkg;

    // Default operand width (valid range 8 to 63)
    localparam int SDIV_DATA_WIDTH = 32;

    // Per-stage control that travels alongside the datapath
    typedef struct packed {
        logic valid;  // stage holds a transaction
        logic neg;    // operand signs differ, result is negated
        logic dz;     // divisor was zero
    } t_ctl;

endpackage

>>> rtl/sdiv_prep.sv
// ============================================================================
// sdiv_prep
// Input stage: registers operand magnitudes, the result sign and the zero-divisor flag.
// ============================================================================
module sdiv_prep
    import sdiv_pkg::*;
#(
    parameter int DATA_WIDTH = SDIV_DATA_WIDTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,
    input  logic                  i_valid,
    input  logic [DATA_WIDTH-1:0] i_numerator,
    input  logic [DATA_WIDTH-1:0] i_denominator,
    output t_ctl                  o_ctl,
    output logic [DATA_WIDTH-1:0] o_mag_a,
    output logic [DATA_WIDTH-1:0] o_mag_b
);

    logic                  r_valid;
    logic                  r_neg;
    logic                  r_dz;
    logic [DATA_WIDTH-1:0] r_mag_a;
    logic [DATA_WIDTH-1:0] r_mag_b;

    logic                  n_neg_a;
    logic                  n_neg_b;
    logic [DATA_WIDTH-1:0] n_mag_a;
    logic [DATA_WIDTH-1:0] n_mag_b;

    // Two's complement magnitudes; the most negative value maps to 2^(W-1)
    always_comb begin
        n_neg_a = i_numerator[DATA_WIDTH-1];
        n_neg_b = i_denominator[DATA_WIDTH-1];
        n_mag_a = n_neg_a ? (~i_numerator + DATA_WIDTH'(1)) : i_numerator;
        n_mag_b = n_neg_b ? (~i_denominator + DATA_WIDTH'(1)) : i_denominator;
    end

    // Control register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_valid;
        end
    end

    // Payload register
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_neg   <= n_neg_a ^ n_neg_b;
            r_dz    <= (i_denominator == '0);
            r_mag_a <= n_mag_a;
            r_mag_b <= n_mag_b;
        end
    end

    assign o_ctl   = '{valid: r_valid, neg: r_neg, dz: r_dz};
    assign o_mag_a = r_mag_a;
    assign o_mag_b = r_mag_b;

endmodule

>>> rtl/sdiv_cell.sv
// ============================================================================
// sdiv_cell
// One restoring-division step: shifts in one dividend bit, resolves one
// quotient bit, and hands the partial remainder to the next cell.
// ============================================================================
module sdiv_cell
    import sdiv_pkg::*;
#(
    parameter int DATA_WIDTH = SDIV_DATA_WIDTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  t_ctl                  i_ctl,
    input  logic [DATA_WIDTH-1:0] i_rem,
    input  logic [DATA_WIDTH-1:0] i_aq,
    input  logic [DATA_WIDTH-1:0] i_div,
    output t_ctl                  o_ctl,
    output logic [DATA_WIDTH-1:0] o_rem,
    output logic [DATA_WIDTH-1:0] o_aq,
    output logic [DATA_WIDTH-1:0] o_div
);

    logic                  r_valid;
    logic                  r_neg;
    logic                  r_dz;
    logic [DATA_WIDTH-1:0] r_rem;
    logic [DATA_WIDTH-1:0] r_aq;
    logic [DATA_WIDTH-1:0] r_div;

    logic [DATA_WIDTH-1:0] n_trial;
    logic                  n_ge;
    logic [DATA_WIDTH-1:0] n_rem;
    logic [DATA_WIDTH-1:0] n_aq;

    // Remainder stays below the divisor, so its top bit is always clear
    // and the shifted trial value fits in DATA_WIDTH bits.
    always_comb begin
        n_trial = {i_rem[DATA_WIDTH-2:0], i_aq[DATA_WIDTH-1]};
        n_ge    = (n_trial >= i_div);
        n_rem   = n_ge ? (n_trial - i_div) : n_trial;
        n_aq    = {i_aq[DATA_WIDTH-2:0], n_ge};
    end

    // Control register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_ctl.valid;
        end
    end

    // Payload register
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg <= i_ctl.neg;
            r_dz  <= i_ctl.dz;
            r_rem <= n_rem;
            r_aq  <= n_aq;
            r_div <= i_div;
        end
    end

    assign o_ctl = '{valid: r_valid, neg: r_neg, dz: r_dz};
    assign o_rem = r_rem;
    assign o_aq  = r_aq;
    assign o_div = r_div;

endmodule

>>> rtl/sdiv_post.sv
// ============================================================================
// sdiv_post
// Output stage: applies the sign, saturates, and holds the result until the
// downstream side takes it.
// ============================================================================
module sdiv_post
    import sdiv_pkg::*;
#(
    parameter int DATA_WIDTH = SDIV_DATA_WIDTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  t_ctl                  i_ctl,
    input  logic [DATA_WIDTH-1:0] i_quo,
    output logic                  o_valid,
    output logic [DATA_WIDTH-1:0] o_quotient
);

    localparam logic [DATA_WIDTH-1:0] POS_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};

    logic                  r_valid;
    logic [DATA_WIDTH-1:0] r_quotient;
    logic [DATA_WIDTH-1:0] n_quotient;

    // Zero divisor and positive overflow both give the positive maximum;
    // a negative magnitude never exceeds 2^(W-1), so it always fits.
    always_comb begin
        if (i_ctl.dz) begin
            n_quotient = POS_MAX;
        end else if (i_ctl.neg) begin
            n_quotient = ~i_quo + DATA_WIDTH'(1);
        end else if (i_quo[DATA_WIDTH-1]) begin
            n_quotient = POS_MAX;
        end else begin
            n_quotient = i_quo;
        end
    end

    // Control register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_ctl.valid;
        end
    end

    // Payload register
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_quotient <= n_quotient;
        end
    end

    assign o_valid    = r_valid;
    assign o_quotient = r_quotient;

endmodule

>>> rtl/signed_int32_divider_saturating_core.sv
// ============================================================================
// signed_int32_divider_saturating_core
// Saturating signed integer divider built as a row of restoring-division
// cells, one quotient bit per cell.
// ============================================================================
// Usage:
//   s_axis carries one division per transaction: tdata holds the numerator
//   in the low DATA_WIDTH bits and the denominator above it, zero padded to
//   whole bytes. m_axis returns one quotient per transaction, truncated
//   toward zero and saturated; a zero divisor returns the positive maximum.
//   The accepting edge loads the input stage; DATA_WIDTH division cells and
//   the output register follow, each a register stage on the way to m_axis.
//   The cell row is pipelined, so one transaction can enter every cycle while
//   the output is not stalled, and results leave in order.
//   When m_axis_tready is low with a result waiting, the whole row holds;
//   the input stage still takes one more transaction if it is empty.
//   Reset clears every stage's valid flag; data in flight is dropped.
// ============================================================================
module signed_int32_divider_saturating_core
    import sdiv_pkg::*;
#(
    parameter int DATA_WIDTH = SDIV_DATA_WIDTH,
    localparam int IN_TW     = ((2 * DATA_WIDTH + 7) / 8) * 8,
    localparam int OUT_TW    = ((DATA_WIDTH + 7) / 8) * 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [IN_TW-1:0]  s_axis_tdata,   // numerator, denominator
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [OUT_TW-1:0] m_axis_tdata    // quotient
);

    localparam logic [DATA_WIDTH-1:0] POS_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};

    logic                  w_en;
    logic                  w_prep_load;
    logic [DATA_WIDTH-1:0] w_quotient;

    t_ctl                  w_ctl [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0] w_rem [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0] w_aq  [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0] w_div [0:DATA_WIDTH];

    // Row advances unless a finished result is stalled at the output
    assign w_en          = !m_axis_tvalid || m_axis_tready;
    assign w_prep_load   = w_en || !w_ctl[0].valid;
    assign s_axis_tready = w_prep_load;

    // Input stage
    sdiv_prep #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_prep (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (w_prep_load),
        .i_valid       (s_axis_tvalid),
        .i_numerator   (s_axis_tdata[DATA_WIDTH-1:0]),
        .i_denominator (s_axis_tdata[2*DATA_WIDTH-1:DATA_WIDTH]),
        .o_ctl         (w_ctl[0]),
        .o_mag_a       (w_aq[0]),
        .o_mag_b       (w_div[0])
    );

    assign w_rem[0] = '0;

    // Division cells, most significant quotient bit first
    for (genvar g = 0; g < DATA_WIDTH; g++) begin : g_cell
        sdiv_cell #(
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_ctl   (w_ctl[g]),
            .i_rem   (w_rem[g]),
            .i_aq    (w_aq[g]),
            .i_div   (w_div[g]),
            .o_ctl   (w_ctl[g+1]),
            .o_rem   (w_rem[g+1]),
            .o_aq    (w_aq[g+1]),
            .o_div   (w_div[g+1])
        );
    end

    // Sign, saturation and output register
    sdiv_post #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_post (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_ctl      (w_ctl[DATA_WIDTH]),
        .i_quo      (w_aq[DATA_WIDTH]),
        .o_valid    (m_axis_tvalid),
        .o_quotient (w_quotient)
    );

    assign m_axis_tdata = OUT_TW'(w_quotient);

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------

    // An accepted transaction lands in the input stage
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> w_ctl[0].valid)
        else $error("accepted transaction not captured by input stage");

    // A zero divisor leaving the last cell yields the positive maximum
    a_zero_div_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_en && w_ctl[DATA_WIDTH].valid && w_ctl[DATA_WIDTH].dz
        |=> m_axis_tvalid && (w_quotient == POS_MAX))
        else $error("zero divisor did not give positive maximum");

    // Same-sign operands never produce a negative quotient
    a_same_sign_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_en && w_ctl[DATA_WIDTH].valid && !w_ctl[DATA_WIDTH].neg
        |=> !w_quotient[DATA_WIDTH-1])
        else $error("same-sign division produced a negative quotient");

    // The input stage advances into the first cell whenever the row moves
    a_row_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_en && w_ctl[0].valid |=> w_ctl[1].valid)
        else $error("input stage did not advance into the first cell");

    // While the output is stalled the first cell holds its contents
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(w_ctl[1].valid) && $stable(w_aq[1]))
        else $error("cell row moved while output was stalled");

endmodule

>>> bench/signed_int32_divider_saturating_core_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// signed_int32_divider_saturating_core_tb
// Self-checking bench for the saturating signed divider.
// ============================================================================
// Drives divisions into s_axis and predicts each quotient with a bit-serial
// restoring divider that has its own sign handling and saturation. Quotients
// leaving m_axis are compared in order against the predictions. A directed
// pass hits the corners first: zero divisor, zero dividend, most negative by
// minus one, and the extremes of both operands. Random passes follow under
// three stall patterns: a slow consumer, a slow producer, then full rate.
// ============================================================================
module signed_int32_divider_saturating_core_tb;
    import sdiv_pkg::*;

    localparam int DW            = SDIV_DATA_WIDTH;
    localparam int WATCHDOG_MAX  = 4000;
    localparam int DRAIN_CYCLES  = DW + 8;
    localparam logic [DW-1:0] QUOT_MAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0] QUOT_MIN = {1'b1, {(DW-1){1'b0}}};
    localparam logic [DW-1:0] MINUS_ONE = {DW{1'b1}};

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [2*DW-1:0]     s_axis_tdata  = '0;   // numerator, denominator
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [DW-1:0]       m_axis_tdata;          // quotient

    // Expected quotients, oldest first
    logic [DW-1:0]       pending_quotients[$];

    int unsigned         sender_idle_pct   = 0;
    int unsigned         receiver_idle_pct = 0;
    int unsigned         divisions_sent    = 0;
    int unsigned         quotients_checked = 0;
    int unsigned         zero_divisor_cnt  = 0;
    int unsigned         overflow_cnt      = 0;
    int unsigned         mismatch_cnt      = 0;
    int unsigned         quiet_cycles      = 0;

    signed_int32_divider_saturating_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Restoring division on magnitudes, then sign and saturation
    function automatic logic [DW-1:0] predict_quotient(input logic [DW-1:0] num,
                                                       input logic [DW-1:0] den);
        logic          num_neg;
        logic          den_neg;
        logic [DW:0]   mag_num;
        logic [DW:0]   mag_den;
        logic [DW:0]   rem;
        logic [DW:0]   quo;
        num_neg = num[DW-1];
        den_neg = den[DW-1];
        mag_num = {1'b0, num_neg ? (~num + 1'b1) : num};
        mag_den = {1'b0, den_neg ? (~den + 1'b1) : den};
        if (mag_den == '0)
            return QUOT_MAX;
        rem = '0;
        quo = '0;
        for (int i = DW - 1; i >= 0; i--) begin
            rem = {rem[DW-1:0], mag_num[i]};
            if (rem >= mag_den) begin
                rem    = rem - mag_den;
                quo[i] = 1'b1;
            end
        end
        if (num_neg == den_neg) begin
            if (quo > {1'b0, QUOT_MAX})
                return QUOT_MAX;
            return quo[DW-1:0];
        end
        // magnitude can reach 2^(DW-1) at most, which still fits negated
        if (quo > {1'b0, QUOT_MIN})
            quo = {1'b0, QUOT_MIN};
        return ~quo[DW-1:0] + 1'b1;
    endfunction

    // Operand of random bit length and random sign
    function automatic logic [DW-1:0] random_operand();
        logic [DW-1:0] val;
        int unsigned   len;
        len = $urandom_range(DW, 1);
        val = $urandom;
        if (len < DW)
            val = val & ((DW'(1) << len) - 1'b1);
        if ($urandom_range(1))
            val = ~val + 1'b1;
        return val;
    endfunction

    // Send one division; returns once the transaction is accepted
    task automatic send_division(input logic [DW-1:0] num, input logic [DW-1:0] den);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {den, num};
        do
            @(posedge i_clk);
        while (!s_axis_tready);
        pending_quotients.push_back(predict_quotient(num, den));
        divisions_sent++;
        if (den == '0)
            zero_divisor_cnt++;
        if (num == QUOT_MIN && den == MINUS_ONE)
            overflow_cnt++;
    endtask

    // Corners of both operands and every special case
    task automatic test_corner_cases();
        send_division(0, 5);
        send_division(0, -5);
        send_division(0, QUOT_MIN);
        send_division(7, 0);
        send_division(-7, 0);
        send_division(0, 0);
        send_division(QUOT_MIN, 0);
        send_division(QUOT_MAX, 0);
        send_division(QUOT_MIN, MINUS_ONE);
        send_division(QUOT_MIN, 1);
        send_division(QUOT_MIN, QUOT_MIN);
        send_division(QUOT_MIN, QUOT_MAX);
        send_division(QUOT_MIN, 2);
        send_division(QUOT_MIN, -2);
        send_division(QUOT_MAX, 1);
        send_division(QUOT_MAX, MINUS_ONE);
        send_division(QUOT_MAX, QUOT_MAX);
        send_division(QUOT_MAX, QUOT_MIN);
        send_division(1, QUOT_MIN);
        send_division(MINUS_ONE, QUOT_MIN);
        send_division(7, 2);
        send_division(-7, 2);
        send_division(7, -2);
        send_division(-7, -2);
        send_division(5, 10);
    endtask

    // Random operands, shaped so quotients of every size show up
    task automatic test_random_divisions(input int unsigned count);
        logic [DW-1:0] num;
        logic [DW-1:0] den;
        int unsigned   pick;
        repeat (count) begin
            pick = $urandom_range(99);
            num  = $urandom;
            den  = $urandom;
            if (pick < 35) begin
                // full-width random on both sides
            end else if (pick < 65) begin
                den = random_operand();
            end else if (pick < 75) begin
                den = $urandom_range(16, 1);
                if ($urandom_range(1))
                    den = ~den + 1'b1;
            end else if (pick < 85) begin
                num = random_operand();
                den = random_operand();
            end else if (pick < 90) begin
                den = $urandom_range(1) ? '0 : ($urandom_range(1) ? MINUS_ONE : DW'(1));
            end else if (pick < 95) begin
                num = QUOT_MIN;
                den = $urandom_range(1) ? MINUS_ONE : random_operand();
            end else begin
                // divisor close to the dividend magnitude
                den = $urandom_range(1) ? num : ~num + 1'b1;
                den = den + DW'($urandom_range(2)) - 1'b1;
            end
            send_division(num, den);
        end
    endtask

    // Slow consumer: results back up through the whole pipeline
    task automatic test_output_backpressure();
        sender_idle_pct   = 8;
        receiver_idle_pct = 71;
        test_random_divisions(360);
    endtask

    // Slow producer: bubbles fall between transactions
    task automatic test_sparse_input();
        sender_idle_pct   = 71;
        receiver_idle_pct = 8;
        test_random_divisions(360);
    endtask

    // Back-to-back transactions with no stalls on either side
    task automatic test_full_rate();
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        test_random_divisions(360);
    endtask

    // Result checker and consumer-side stall generator
    always @(posedge i_clk) begin
        logic [DW-1:0] want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_quotients.size() == 0) begin
                $error("unexpected quotient 0x%08h with nothing pending", m_axis_tdata);
                mismatch_cnt++;
            end else begin
                want = pending_quotients.pop_front();
                quotients_checked++;
                if (m_axis_tdata !== want) begin
                    $error("quotient mismatch: expected %0d, got %0d",
                           $signed(want), $signed(m_axis_tdata));
                    mismatch_cnt++;
                end
            end
        end
        m_axis_tready <= ($urandom_range(99) >= receiver_idle_pct);
    end

    // Watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_MAX) begin
            $display("watchdog: no transaction for %0d cycles", WATCHDOG_MAX);
            $display("Some tests failed");
            $finish;
        end
    end

    // Test sequence
    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        sender_idle_pct   = 8;
        receiver_idle_pct = 71;
        test_corner_cases();
        test_output_backpressure();
        test_sparse_input();
        test_full_rate();
        s_axis_tvalid <= 1'b0;

        // drain, then give stray results a chance to appear
        while (pending_quotients.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d divisions (%0d by zero, %0d overflowing) over three stall patterns",
                 divisions_sent, zero_divisor_cnt, overflow_cnt);
        $display("Checked %0d quotients, %0d mismatches", quotients_checked, mismatch_cnt);
        if (mismatch_cnt == 0 && quotients_checked == divisions_sent)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
